@@ hw/rtl/smpq_pkg.sv @@
package smpq_pkg;

    // Default number of entries the queue can hold.
    localparam int SMPQ_CAPACITY = 16;

    // Width of the reported fill count, fixed by the result format.
    localparam int FILL_W = 5;

    // Operation carried by an input transaction.
    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } t_cmd;

    // Outcome reported with every result transaction.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One held entry.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_entry;

    // Input transaction payload.
    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_in;

    // Result transaction payload.
    typedef struct packed {
        t_status             status;
        logic signed [31:0]  taken_value;
        logic signed [31:0]  taken_priority;
        logic signed [31:0]  top_value;
        logic signed [31:0]  top_priority;
        logic                is_empty;
        logic [FILL_W-1:0]   fill;
    } t_out;

    // Per-step control broadcast to every slot.
    typedef struct packed {
        logic insert;
        logic extract;
    } t_cell_ctl;

endpackage

@@ hw/rtl/smpq_cell.sv @@
module smpq_cell
    import smpq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_entry    i_new,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    input  logic      i_prev_ge,
    output t_entry    o_entry,
    output logic      o_ge
);

    t_entry r_entry;
    t_entry n_entry;

    // A held entry whose priority is at least the new one stays ahead of it.
    assign o_ge = i_valid && ($signed(r_entry.prio) >= $signed(i_new.prio));

    // Keep, take the new entry, shift down on insert, or shift up on extract.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.extract) begin
            n_entry = i_next;
        end else if (i_ctl.insert && !o_ge) begin
            n_entry = i_prev_ge ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ hw/rtl/sorted_max_priority_queue_unit.sv @@
// Sorted max-priority queue built as a row of shift-register slots.
// Input channel (i_in_valid / o_in_ready / i_in_data): each transaction is an
// insert or an extract. Output channel (o_out_valid / i_out_ready /
// o_out_data): exactly one result transaction per input transaction, in order.
// An accepted transaction is held in an input register; once the output
// register is free or being emptied, every slot compares its priority with the
// new one in parallel and the whole row shifts or holds in a single step, while
// the result is written to the output register, which drives o_out_valid. One
// transaction per cycle is sustained as long as the receiver takes results.
// Equal priorities leave in arrival order. Inserting into a full
// queue is rejected with status full, extracting from an empty queue returns
// status empty; neither changes the contents.
// Reset empties the queue and drops any transaction in flight; slot contents
// are not cleared, only the entry count.
// When the receiver stalls, the result stays in the output register, one more
// transaction may wait in the input register, and then o_in_ready falls.
module sorted_max_priority_queue_unit
    import smpq_pkg::*;
#(
    parameter int CAPACITY = SMPQ_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             r_in_valid;
    t_in              r_in;
    logic             r_out_valid;
    t_out             r_out;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic      w_proc;
    logic      w_full;
    logic      w_empty;
    logic      w_ins_ok;
    logic      w_ext_ok;
    t_cell_ctl w_ctl;
    t_entry    w_new;
    t_entry    w_slot [CAPACITY];
    logic      w_ge   [CAPACITY];
    t_out      n_out;
    logic [FILL_W+CNT_W-1:0] w_fill_ext;

    // A transaction in the input register is processed when the output register
    // is free or being emptied in the same cycle.
    assign w_proc     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_proc;

    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_ins_ok = w_proc && (r_in.cmd == CMD_INSERT) && !w_full;
    assign w_ext_ok = w_proc && (r_in.cmd == CMD_EXTRACT) && !w_empty;

    assign w_ctl.insert  = w_ins_ok;
    assign w_ctl.extract = w_ext_ok;

    assign w_new.value = r_in.item_value;
    assign w_new.prio  = r_in.item_priority;

    // Row of slots, head at index zero.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_ge;

        if (i == 0) begin : g_head
            assign w_prev    = w_new;
            assign w_prev_ge = 1'b1;
        end else begin : g_body
            assign w_prev    = w_slot[i-1];
            assign w_prev_ge = w_ge[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_next = w_slot[i];
        end else begin : g_mid
            assign w_next = w_slot[i+1];
        end

        smpq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_valid   (CNT_W'(i) < r_count),
            .i_new     (w_new),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .i_prev_ge (w_prev_ge),
            .o_entry   (w_slot[i]),
            .o_ge      (w_ge[i])
        );
    end

    // Entry count after this step.
    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ext_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_fill_ext = {{FILL_W{1'b0}}, n_count};

    // Result of this step, including the head as it will be afterwards.
    always_comb begin
        n_out                = '0;
        n_out.status         = ST_DONE;
        n_out.fill           = w_fill_ext[FILL_W-1:0];
        n_out.is_empty       = (n_count == '0);
        if (r_in.cmd == CMD_INSERT && w_full) begin
            n_out.status = ST_FULL;
        end else if (r_in.cmd == CMD_EXTRACT && w_empty) begin
            n_out.status = ST_EMPTY;
        end
        if (w_ext_ok) begin
            n_out.taken_value    = w_slot[0].value;
            n_out.taken_priority = w_slot[0].prio;
        end
        if (n_count != '0) begin
            if (w_ins_ok && !w_ge[0]) begin
                n_out.top_value    = w_new.value;
                n_out.top_priority = w_new.prio;
            end else if (w_ext_ok) begin
                n_out.top_value    = w_slot[1].value;
                n_out.top_priority = w_slot[1].prio;
            end else begin
                n_out.top_value    = w_slot[0].value;
                n_out.top_priority = w_slot[0].prio;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The entry count never goes past the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // An accepted insert into a queue with room grows it by exactly one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the queue by one");

    // Extract on an empty queue reports empty and leaves the count alone.
    a_empty_extract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.cmd == CMD_EXTRACT && w_empty) |=>
            (r_out_valid && r_out.status == ST_EMPTY && r_count == '0))
        else $error("extract on empty queue misreported");

    // The two front slots stay in descending priority order.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |->
            ($signed(w_slot[0].prio) >= $signed(w_slot[1].prio)))
        else $error("head slots out of priority order");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import smpq_pkg::*;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_LIMIT   = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // One directed transaction, with the result written out by hand where it is obvious.
    typedef struct {
        t_in  op;
        bit   typed;
        t_out want;
    } t_row;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data  = '0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // Shadow copy of the queue contents, head at index 0.
    logic signed [31:0] shadow_val [SMPQ_CAPACITY];
    logic signed [31:0] shadow_pri [SMPQ_CAPACITY];
    int shadow_count = 0;

    t_out awaited_reports [$];
    bit   sender_gaps = 1'b1;
    int   error_count = 0;
    int   result_index = 0;
    int   insert_count = 0;
    int   extract_count = 0;
    int   full_count = 0;
    int   empty_count = 0;
    int   peak_fill = 0;
    int   idle_cycles = 0;

    sorted_max_priority_queue_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock generation.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one operation to the shadow queue and returns the result it must produce.
    function automatic t_out predict_queue_op(input t_in op);
        t_out res;
        int pos;
        res = '0;
        res.status = ST_DONE;
        if (op.cmd == CMD_INSERT) begin
            insert_count++;
            if (shadow_count >= SMPQ_CAPACITY) begin
                res.status = ST_FULL;
                full_count++;
            end else begin
                // New entry goes behind every entry of greater or equal priority.
                pos = 0;
                while (pos < shadow_count && shadow_pri[pos] >= op.item_priority) pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_val[i] = shadow_val[i-1];
                    shadow_pri[i] = shadow_pri[i-1];
                end
                shadow_val[pos] = op.item_value;
                shadow_pri[pos] = op.item_priority;
                shadow_count++;
            end
        end else begin
            extract_count++;
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
                empty_count++;
            end else begin
                res.taken_value    = shadow_val[0];
                res.taken_priority = shadow_pri[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_val[i-1] = shadow_val[i];
                    shadow_pri[i-1] = shadow_pri[i];
                end
                shadow_count--;
            end
        end
        if (shadow_count != 0) begin
            res.top_value    = shadow_val[0];
            res.top_priority = shadow_pri[0];
        end
        res.is_empty = (shadow_count == 0);
        res.fill = FILL_W'(shadow_count);
        if (shadow_count > peak_fill) peak_fill = shadow_count;
        return res;
    endfunction

    function automatic t_in mk_op(input t_cmd c, input logic signed [31:0] v,
                                  input logic signed [31:0] p);
        t_in op;
        op.cmd = c;
        op.item_value = v;
        op.item_priority = p;
        return op;
    endfunction

    function automatic t_out mk_report(input t_status s,
                                       input logic signed [31:0] tv, input logic signed [31:0] tp,
                                       input logic signed [31:0] hv, input logic signed [31:0] hp,
                                       input logic e, input logic [FILL_W-1:0] f);
        t_out r;
        r.status = s;
        r.taken_value = tv;
        r.taken_priority = tp;
        r.top_value = hv;
        r.top_priority = hp;
        r.is_empty = e;
        r.fill = f;
        return r;
    endfunction

    // Random operation; priorities lean toward a narrow band so that ties are common.
    function automatic t_in random_op(input int insert_pct);
        t_in op;
        op.cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
        op.item_value = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: op.item_priority = $signed($urandom_range(0, 6)) - 3;
            8:             op.item_priority = S32_MAX;
            9:             op.item_priority = S32_MIN;
            default:       op.item_priority = $urandom;
        endcase
        return op;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("Mismatch in result %0d, %s: expected %h, got %h",
                         result_index, name, want, got);
        end
    endfunction

    // Checks one received result transaction against the oldest expectation.
    function automatic void check_report(input t_out got);
        t_out want;
        if (awaited_reports.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("Result %0d arrived with nothing expected: %p", result_index, got);
        end else begin
            want = awaited_reports.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("taken_value", want.taken_value, got.taken_value);
            compare_field("taken_priority", want.taken_priority, got.taken_priority);
            compare_field("top_value", want.top_value, got.top_value);
            compare_field("top_priority", want.top_priority, got.top_priority);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("fill", want.fill, got.fill);
        end
        result_index++;
    endfunction

    // Presents one transaction, after a random gap if sender_gaps is set, and records its expected result.
    task automatic send_op(input t_in op, input bit typed, input t_out want);
        t_out predicted;
        int gap;
        gap = sender_gaps ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= op;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        predicted = predict_queue_op(op);
        awaited_reports.push_back(typed ? want : predicted);
    endtask

    // Result side: random stalls per transaction, with stretches of none.
    initial begin
        int stall;
        int taken;
        bit stall_on;
        taken = 0;
        stall_on = 1'b1;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (taken % 30 == 0) stall_on = ($urandom_range(0, 3) != 0);
            stall = stall_on ? $urandom_range(0, 8) : 0;
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!o_out_valid) @(posedge clk);
            check_report(o_out_data);
            taken++;
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    initial begin
        do @(posedge clk); while (!rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, awaited_reports.size());
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus: directed table, then random bursts of varying insert/extract mix.
    initial begin
        t_row script [$];
        int sent;
        int burst_len;
        int insert_pct;

        // Extract on empty ignores its data fields.
        script.push_back('{mk_op(CMD_EXTRACT, -32'sd1, S32_MAX), 1'b1,
                           mk_report(ST_EMPTY, 0, 0, 0, 0, 1'b1, 0)});
        // First entry at the highest priority becomes the head.
        script.push_back('{mk_op(CMD_INSERT, S32_MAX, S32_MAX), 1'b1,
                           mk_report(ST_DONE, 0, 0, S32_MAX, S32_MAX, 1'b0, 1)});
        // Extremes, ties at zero and at both ends, mixed signs; fills the queue.
        script.push_back('{mk_op(CMD_INSERT, S32_MIN, S32_MIN), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 0, 0), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 1, 0), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 2, -1), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 3, S32_MAX), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 4, S32_MIN), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, -1, 1), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 5, 0), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 6, -2), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 7, 1), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 8, S32_MAX - 1), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 9, S32_MIN + 1), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 10, 0), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 11, 100), 1'b0, '0});
        script.push_back('{mk_op(CMD_INSERT, 12, -100), 1'b0, '0});
        // Queue is full: the insert is rejected and the head stays the first entry.
        script.push_back('{mk_op(CMD_INSERT, 13, S32_MAX), 1'b1,
                           mk_report(ST_FULL, 0, 0, S32_MAX, S32_MAX, 1'b0, 16)});
        // Drain part of it to see tie order at the head.
        repeat (6) script.push_back('{mk_op(CMD_EXTRACT, 0, 0), 1'b0, '0});

        // Reset once, before the directed table runs.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[n]) send_op(script[n].op, script[n].typed, script[n].want);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       insert_pct = 25;
                1:       insert_pct = 50;
                default: insert_pct = 85;
            endcase
            burst_len = $urandom_range(10, 40);
            sender_gaps = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
                send_op(random_op(insert_pct), 1'b0, '0);
                sent++;
            end
        end
        in_valid <= 1'b0;

        // Wait for every outstanding result, then drain for strays.
        while (awaited_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d inserts and %0d extracts, peak fill %0d of %0d.",
                 insert_count, extract_count, peak_fill, SMPQ_CAPACITY);
        $display("%0d inserts rejected as full, %0d extracts on empty, %0d mismatches.",
                 full_count, empty_count, error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
